[rtl/core/ksss_pkg.sv]
`default_nettype none

package ksss_pkg;

   localparam int DATA_W = 32;
   localparam int KW     = 4;

   // One sorted result on its way to the response register.
   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     last;
   } result_type;

endpackage

`default_nettype wire

[rtl/core/k_sorted_stream_sorter.sv]
`default_nettype none

// Sorter for almost-sorted streams. Every sample that arrives on the req_
// channel is pushed into a binary min-heap held in a small synchronous RAM.
// Once the heap holds more than k+1 values (k = csr window register, capped
// at STORE_DEPTH-2) the smallest value is popped and sent on the rsp_
// channel. A sample flagged end_of_sequence is pushed and then the whole
// heap is drained in ascending signed order; rsp_run_last marks the final
// value, and the heap is empty for the next sequence. Equal values may
// leave in either order. One transaction is worked on at a time. The time a
// push takes grows with the heap levels climbed, and the time a pop takes
// with the levels the refilled hole sinks; both are set by the single
// read-compare-write per heap level through the RAM. A drain costs one pop
// per stored value. The next req_ transaction is taken while a result still
// waits in the rsp_ register; a pop waits only while that register is full
// and stalled. Write the window register only while the block is idle.
module k_sorted_stream_sorter
   import ksss_pkg::*;
#(
   parameter int STORE_DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_wr_en,
   input  wire logic [KW-1:0]            csr_wr_data,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic signed [DATA_W-1:0] req_sample,
   input  wire logic                     req_end_of_sequence,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed [DATA_W-1:0]      rsp_sorted_value,
   output logic                          rsp_run_last
);

   localparam int AW = $clog2(STORE_DEPTH);

   // RAM port wiring
   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   logic signed [DATA_W-1:0] wr_data;
   logic [AW-1:0]            rd_addr_a;
   logic [AW-1:0]            rd_addr_b;
   logic signed [DATA_W-1:0] rd_data_a;
   logic signed [DATA_W-1:0] rd_data_b;

   // Result hand-off to the output register
   logic                     slot_free;
   logic                     res_load;
   result_type               res;

   ksss_heap_ram #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // Sequencer: push / sift-up, pop / sift-down, drain control
   ksss_heap_ctrl #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_sample          (req_sample),
      .req_end_of_sequence (req_end_of_sequence),
      .wr_en               (wr_en),
      .wr_addr             (wr_addr),
      .wr_data             (wr_data),
      .rd_addr_a           (rd_addr_a),
      .rd_addr_b           (rd_addr_b),
      .rd_data_a           (rd_data_a),
      .rd_data_b           (rd_data_b),
      .slot_free           (slot_free),
      .res_load            (res_load),
      .res                 (res)
   );

   // Output register decouples the consumer from the heap sequencer
   ksss_rsp_reg u_rsp (
      .clock            (clock),
      .reset            (reset),
      .load             (res_load),
      .result           (res),
      .slot_free        (slot_free),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_run_last     (rsp_run_last)
   );

endmodule

`default_nettype wire

[rtl/core/ksss_heap_ram.sv]
`default_nettype none

// Heap storage: one write port, two registered read ports.
module ksss_heap_ram
   import ksss_pkg::*;
#(
   parameter int STORE_DEPTH = 16,
   localparam int AW = $clog2(STORE_DEPTH)
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [AW-1:0]            wr_addr,
   input  wire logic signed [DATA_W-1:0] wr_data,
   input  wire logic [AW-1:0]            rd_addr_a,
   input  wire logic [AW-1:0]            rd_addr_b,
   output logic signed [DATA_W-1:0]      rd_data_a,
   output logic signed [DATA_W-1:0]      rd_data_b
);

   logic signed [DATA_W-1:0] mem [STORE_DEPTH];
   logic signed [DATA_W-1:0] rd_a_ff;
   logic signed [DATA_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

[rtl/core/ksss_rsp_reg.sv]
`default_nettype none

// Output register: holds one result until the consumer takes it.
module ksss_rsp_reg
   import ksss_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire result_type          result,
   output logic                     slot_free,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic signed [DATA_W-1:0] rsp_sorted_value,
   output logic                     rsp_run_last
);

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   assign valid_in  = load | (valid_ff & rsp_stall);
   assign slot_free = ~valid_ff | ~rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_sorted_value = data_ff.value;
   assign rsp_run_last     = data_ff.last;

endmodule

`default_nettype wire

[rtl/core/ksss_heap_ctrl.sv]
`default_nettype none

// Heap sequencer: hole-based sift-up on insert, sift-down on extract.
module ksss_heap_ctrl
   import ksss_pkg::*;
#(
   parameter int STORE_DEPTH = 16,
   localparam int AW = $clog2(STORE_DEPTH)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_wr_en,
   input  wire logic [KW-1:0]            csr_wr_data,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic signed [DATA_W-1:0] req_sample,
   input  wire logic                     req_end_of_sequence,
   output logic                          wr_en,
   output logic [AW-1:0]                 wr_addr,
   output logic signed [DATA_W-1:0]      wr_data,
   output logic [AW-1:0]                 rd_addr_a,
   output logic [AW-1:0]                 rd_addr_b,
   input  wire logic signed [DATA_W-1:0] rd_data_a,
   input  wire logic signed [DATA_W-1:0] rd_data_b,
   input  wire logic                     slot_free,
   output logic                          res_load,
   output result_type                    res
);

   localparam int CW   = $clog2(STORE_DEPTH + 1);
   localparam int CMPW = (CW > KW + 1) ? CW : KW + 1;
   localparam int XW   = AW + 2;
   localparam int KMAX = STORE_DEPTH - 2;

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_UP      = 7'b0000010,
      S_FIN     = 7'b0000100,
      S_DECIDE  = 7'b0001000,
      S_EXT_RD  = 7'b0010000,
      S_EXT_TOP = 7'b0100000,
      S_DN      = 7'b1000000
   } state_type;

   state_type                state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [AW-1:0]            idx_ff, idx_in;
   logic signed [DATA_W-1:0] hole_ff, hole_in;
   logic                     eos_ff, eos_in;
   logic                     took_ff, took_in;
   logic [KW-1:0]            window_ff;

   logic [CMPW-1:0]          k_ext, k_sat, count_cmp;
   logic [AW-1:0]            idx_parent, idx_grand, count_parent;
   logic [XW-1:0]            left_x, right_x, count_x;
   logic                     left_ok, right_ok, pick_right;
   logic [AW-1:0]            child_idx;
   logic signed [DATA_W-1:0] child_val;

   // Window saturates so the store can never overflow.
   assign k_ext     = CMPW'(window_ff);
   assign k_sat     = (k_ext > CMPW'(KMAX)) ? CMPW'(KMAX) : k_ext;
   assign count_cmp = CMPW'(count_ff);

   assign idx_parent   = (idx_ff - AW'(1)) >> 1;
   assign idx_grand    = (idx_parent - AW'(1)) >> 1;
   assign count_parent = AW'((count_ff - CW'(1)) >> 1);

   assign left_x     = {1'b0, idx_ff, 1'b1};
   assign right_x    = left_x + XW'(1);
   assign count_x    = XW'(count_ff);
   assign left_ok    = left_x < count_x;
   assign right_ok   = right_x < count_x;
   assign pick_right = right_ok && (rd_data_b < rd_data_a);
   assign child_idx  = pick_right ? right_x[AW-1:0] : left_x[AW-1:0];
   assign child_val  = pick_right ? rd_data_b : rd_data_a;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      hole_in   = hole_ff;
      eos_in    = eos_ff;
      took_in   = took_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_ff;
      wr_data   = hole_ff;
      rd_addr_a = left_x[AW-1:0];
      rd_addr_b = right_x[AW-1:0];
      res_load  = 1'b0;
      res.value = rd_data_a;
      res.last  = eos_ff && (count_ff == '0);
      req_stall = (state_ff != S_IDLE);

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               hole_in = req_sample;
               eos_in  = req_end_of_sequence;
               took_in = 1'b0;
               if (count_ff == CW'(STORE_DEPTH)) begin
                  state_in = S_DECIDE;
               end else if (count_ff == '0) begin
                  wr_en    = 1'b1;
                  wr_addr  = '0;
                  wr_data  = req_sample;
                  count_in = CW'(1);
                  state_in = S_DECIDE;
               end else begin
                  idx_in    = count_ff[AW-1:0];
                  rd_addr_a = count_parent;
                  count_in  = count_ff + CW'(1);
                  state_in  = S_UP;
               end
            end
         end
         S_UP: begin
            wr_en = 1'b1;
            if (hole_ff < rd_data_a) begin
               // Parent moves down into the hole.
               wr_data = rd_data_a;
               idx_in  = idx_parent;
               if (idx_parent == '0) begin
                  state_in = S_FIN;
               end else begin
                  rd_addr_a = idx_grand;
               end
            end else begin
               state_in = S_DECIDE;
            end
         end
         S_FIN: begin
            wr_en    = 1'b1;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if ((eos_ff && count_ff != '0) ||
                (!eos_ff && !took_ff && count_cmp > k_sat + CMPW'(1))) begin
               state_in = S_EXT_RD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_EXT_RD: begin
            if (slot_free) begin
               rd_addr_a = '0;
               rd_addr_b = AW'(count_ff - CW'(1));
               count_in  = count_ff - CW'(1);
               state_in  = S_EXT_TOP;
            end
         end
         S_EXT_TOP: begin
            res_load = 1'b1;
            took_in  = 1'b1;
            hole_in  = rd_data_b;
            idx_in   = '0;
            if (count_ff == '0) begin
               state_in = S_DECIDE;
            end else begin
               rd_addr_a = AW'(1);
               rd_addr_b = AW'(2);
               state_in  = S_DN;
            end
         end
         S_DN: begin
            wr_en = 1'b1;
            if (left_ok && (child_val < hole_ff)) begin
               // Smaller child moves up into the hole.
               wr_data = child_val;
               idx_in  = child_idx;
               state_in = S_DN;
               rd_addr_a = AW'({child_idx, 1'b1});
               rd_addr_b = AW'({child_idx, 1'b1} + (AW + 1)'(1));
            end else begin
               state_in = S_DECIDE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         took_ff   <= 1'b0;
         eos_ff    <= 1'b0;
         window_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         took_ff  <= took_in;
         eos_ff   <= eos_in;
         if (csr_wr_en) begin
            window_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      hole_ff <= hole_in;
   end

endmodule

`default_nettype wire
